// ===== rtl/dass_pkg.sv =====
// ----------------------------------------------------------------------------
// dass_pkg
// Shared types, codes and helpers for the address search sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dass_pkg;

    localparam int ADDRESS_BITS = 24;
    localparam int MAX_RESULTS  = 4;

    localparam logic [ADDRESS_BITS-1:0] ADDR_ALL_ONES = {ADDRESS_BITS{1'b1}};
    localparam logic [4:0]              BIT_TOP       = 5'(ADDRESS_BITS - 1);
    localparam logic [7:0]              SHORT_NONE    = 8'hFF;
    localparam logic [23:0]             WAIT_MS       = 24'd1000;

    // operation codes
    localparam logic [1:0] OP_START_ASSIGN = 2'd0;
    localparam logic [1:0] OP_START_QUERY  = 2'd1;
    localparam logic [1:0] OP_ANSWER       = 2'd2;

    // bus commands
    localparam logic [3:0] CMD_INIT      = 4'd0;
    localparam logic [3:0] CMD_RAND      = 4'd1;
    localparam logic [3:0] CMD_WAIT      = 4'd2;
    localparam logic [3:0] CMD_COMPARE   = 4'd3;
    localparam logic [3:0] CMD_QUERY     = 4'd4;
    localparam logic [3:0] CMD_PROGRAM   = 4'd5;
    localparam logic [3:0] CMD_VERIFY    = 4'd6;
    localparam logic [3:0] CMD_WITHDRAW  = 4'd7;
    localparam logic [3:0] CMD_TERMINATE = 4'd8;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_VERIFY_FAIL = 3'd1;
    localparam logic [2:0] ST_MISMATCH    = 3'd2;
    localparam logic [2:0] ST_NONE_FOUND  = 3'd3;
    localparam logic [2:0] ST_FINISHED    = 3'd4;

    // sequencer phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_ALL    = 4'd1;
    localparam logic [3:0] PH_BITS   = 4'd2;
    localparam logic [3:0] PH_FIX    = 4'd3;
    localparam logic [3:0] PH_CHECK  = 4'd4;
    localparam logic [3:0] PH_QUERY  = 4'd5;
    localparam logic [3:0] PH_VERIFY = 4'd6;

    // register indexes on the config port
    localparam logic REG_SHORT_ANSWER_LIMIT = 1'b0;
    localparam logic REG_MAX_DEVICES        = 1'b1;

    typedef struct packed {
        logic [3:0]              phase;
        logic [4:0]              bit_position;
        logic [ADDRESS_BITS-1:0] probe_addr;
        logic [6:0]              devices_found;
        logic                    assign_mode;
        logic [7:0]              decoded_short;
    } t_state;

    // one bus command with its status snapshot
    typedef struct packed {
        logic [3:0]              command;
        logic [23:0]             command_data;
        logic                    wants_answer;
        logic [6:0]              device_count;
        logic [ADDRESS_BITS-1:0] found_long_address;
        logic [7:0]              dev_short;
        logic [2:0]              status;
    } t_rec;

    // all commands caused by one input beat
    typedef struct packed {
        logic [2:0]                  num;
        t_rec [MAX_RESULTS-1:0]      recs;
    } t_bundle;

    function automatic t_rec mk_rec(
        input logic [3:0]              cmd,
        input logic [23:0]             data,
        input logic                    wants,
        input t_state                  st,
        input logic [2:0]              status
    );
        t_rec r;
        r.command            = cmd;
        r.command_data       = data;
        r.wants_answer       = wants;
        r.device_count       = st.devices_found;
        r.found_long_address = st.probe_addr;
        r.dev_short          = st.decoded_short;
        r.status             = status;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dali_address_search_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// dali_address_search_sequencer_unit
// Commissioning sequencer: start beats and bus answers in, bus commands out.
// ----------------------------------------------------------------------------
// On an accepted input beat the sequencer state updates at once and the up to
// four commands it causes, if any, are stored as a group in a two-entry
// output queue. Commands leave one per cycle on the output channel while it is
// not stalled, the last of a group flagged by o_last_of_run. A new input beat is
// accepted in any cycle in which the queue holds fewer than two groups, so the
// sustained input rate is set by the single output port: four commands after a
// start in assign mode, one for an ordinary compare answer.
// Configuration is on an APB port: limit at 0x0, max_devices at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

module dali_address_search_sequencer_unit import dass_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_operation,
    input  wire  [7:0]  i_group_select,
    input  wire         i_answer_present,
    input  wire  [7:0]  i_answer_byte,
    // output channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [3:0]  o_command,
    output logic [23:0] o_command_data,
    output logic        o_wants_answer,
    output logic        o_last_of_run,
    output logic [6:0]  o_device_count,
    output logic [23:0] o_found_long_address,
    output logic [7:0]  o_dev_short,
    output logic [2:0]  o_status
);

    logic [7:0] r_short_answer_limit;
    logic [6:0] r_max_devices;
    t_state     r_state;
    t_state     n_state;
    t_bundle    n_bundle;
    t_bundle    r_fifo [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] r_sub;
    t_bundle    head;
    t_rec       cur;
    logic       in_beat;
    logic       out_beat;
    logic       push;
    logic       pop;
    logic       head_last;

    // config registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_answer_limit <= 8'd127;
            r_max_devices        <= 7'd64;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_SHORT_ANSWER_LIMIT: r_short_answer_limit <= pwdata[7:0];
                REG_MAX_DEVICES:        r_max_devices        <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SHORT_ANSWER_LIMIT: prdata = {24'd0, r_short_answer_limit};
            REG_MAX_DEVICES:        prdata = {25'd0, r_max_devices};
            default:                prdata = '0;
        endcase
    end

    // sequencer step
    dass_step u_step (
        .i_state              (r_state),
        .i_short_answer_limit (r_short_answer_limit),
        .i_max_devices        (r_max_devices),
        .i_operation          (i_operation),
        .i_group_select       (i_group_select),
        .i_answer_present     (i_answer_present),
        .i_answer_byte        (i_answer_byte),
        .o_state              (n_state),
        .o_bundle             (n_bundle)
    );

    assign o_in_stall = (r_count == 2'd2);
    assign in_beat    = i_in_valid && !o_in_stall;
    assign push       = in_beat && (n_bundle.num != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_IDLE;
            r_state.bit_position   <= BIT_TOP;
            r_state.probe_addr     <= '0;
            r_state.devices_found  <= '0;
            r_state.assign_mode    <= 1'b0;
            r_state.decoded_short  <= SHORT_NONE;
        end else if (in_beat) begin
            r_state <= n_state;
        end
    end

    // output queue of command groups
    assign head      = r_fifo[r_rd_ptr];
    assign cur       = head.recs[r_sub];
    assign head_last = ({1'b0, r_sub} == (head.num - 3'd1));
    assign out_beat  = o_out_valid && !i_out_stall;
    assign pop       = out_beat && head_last;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= n_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_sub    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_sub    <= 2'd0;
            end else if (out_beat) begin
                r_sub <= r_sub + 2'd1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // result beat fields
    assign o_out_valid          = (r_count != 2'd0);
    assign o_command            = cur.command;
    assign o_command_data       = cur.command_data;
    assign o_wants_answer       = cur.wants_answer;
    assign o_last_of_run        = head_last;
    assign o_device_count       = cur.device_count;
    assign o_found_long_address = cur.found_long_address;
    assign o_dev_short          = cur.dev_short;
    assign o_status             = cur.status;

endmodule

`default_nettype wire

// ===== rtl/dass_step.sv =====
// ----------------------------------------------------------------------------
// dass_step
// Next state and command list for one input beat of the search sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dass_step import dass_pkg::*; (
    input  var t_state     i_state,
    input  wire  [7:0]     i_short_answer_limit,
    input  wire  [6:0]     i_max_devices,
    input  wire  [1:0]     i_operation,
    input  wire  [7:0]     i_group_select,
    input  wire            i_answer_present,
    input  wire  [7:0]     i_answer_byte,
    output t_state         o_state,
    output t_bundle        o_bundle
);

    t_state                  st;
    t_rec [MAX_RESULTS-1:0]  recs;
    logic [2:0]              k;
    logic                    do_begin;
    logic                    do_close;
    logic [2:0]              close_status;
    logic [ADDRESS_BITS-1:0] bit_mask;
    logic [ADDRESS_BITS-1:0] next_mask;
    logic [ADDRESS_BITS-1:0] trial;
    logic [7:0]              ans;
    logic [7:0]              check_short;
    logic                    has_verify;
    logic [2:0]              end_status;

    always_comb begin
        st           = i_state;
        recs         = '0;
        k            = 3'd0;
        do_begin     = 1'b0;
        do_close     = 1'b0;
        close_status = ST_OK;
        bit_mask     = ADDRESS_BITS'(1) << i_state.bit_position;
        next_mask    = ADDRESS_BITS'(1) << (i_state.bit_position - 5'd1);
        trial        = '0;
        ans          = i_answer_present ? i_answer_byte : 8'd0;
        check_short  = SHORT_NONE;
        has_verify   = 1'b0;
        end_status   = (i_state.devices_found == 7'd0) ? ST_NONE_FOUND : ST_FINISHED;

        case (i_operation)
            OP_START_ASSIGN, OP_START_QUERY: begin
                st.assign_mode    = (i_operation == OP_START_ASSIGN);
                st.devices_found  = '0;
                st.decoded_short  = SHORT_NONE;
                st.probe_addr     = '0;
                st.bit_position   = BIT_TOP;
                recs[0] = mk_rec(CMD_INIT, {16'd0, i_group_select}, 1'b0, st, ST_OK);
                k = 3'd1;
                if (st.assign_mode) begin
                    recs[1] = mk_rec(CMD_RAND, 24'd0, 1'b0, st, ST_OK);
                    recs[2] = mk_rec(CMD_WAIT, WAIT_MS, 1'b0, st, ST_OK);
                    k = 3'd3;
                end
                do_begin = 1'b1;
            end
            OP_ANSWER: begin
                case (i_state.phase)
                    // broad compare: anyone left on the bus
                    PH_ALL: begin
                        if (!i_answer_present) begin
                            st.phase = PH_IDLE;
                            recs[0]  = mk_rec(CMD_TERMINATE, 24'd0, 1'b0, st, end_status);
                        end else begin
                            st.bit_position   = BIT_TOP;
                            st.probe_addr     = ADDRESS_BITS'(1) << BIT_TOP;
                            st.phase          = PH_BITS;
                            recs[0] = mk_rec(CMD_COMPARE, st.probe_addr, 1'b1, st, ST_OK);
                        end
                        k = 3'd1;
                    end
                    // one bit of successive approximation per answer
                    PH_BITS: begin
                        trial = i_answer_present ? (i_state.probe_addr & ~bit_mask)
                                                 : i_state.probe_addr;
                        st.probe_addr = trial;
                        if (i_state.bit_position == 5'd0) begin
                            if (trial == '0 || trial == ADDR_ALL_ONES) begin
                                st.phase = PH_IDLE;
                                recs[0]  = mk_rec(CMD_TERMINATE, 24'd0, 1'b0, st, end_status);
                            end else begin
                                st.phase = PH_FIX;
                                recs[0]  = mk_rec(CMD_COMPARE, trial, 1'b1, st, ST_OK);
                            end
                        end else begin
                            st.bit_position   = i_state.bit_position - 5'd1;
                            st.probe_addr     = trial | next_mask;
                            recs[0] = mk_rec(CMD_COMPARE, st.probe_addr, 1'b1, st, ST_OK);
                        end
                        k = 3'd1;
                    end
                    // final step: address moves one above the probe if the probe drew no answer
                    PH_FIX: begin
                        if (!i_answer_present) begin
                            st.probe_addr = i_state.probe_addr + ADDRESS_BITS'(1);
                        end
                        st.phase = PH_CHECK;
                        recs[0]  = mk_rec(CMD_COMPARE, st.probe_addr, 1'b1, st, ST_OK);
                        k = 3'd1;
                    end
                    PH_CHECK: begin
                        if (!i_answer_present) begin
                            st.phase = PH_IDLE;
                            recs[0]  = mk_rec(CMD_TERMINATE, 24'd0, 1'b0, st, ST_MISMATCH);
                        end else begin
                            st.phase = PH_QUERY;
                            recs[0]  = mk_rec(CMD_QUERY, 24'd0, 1'b1, st, ST_OK);
                        end
                        k = 3'd1;
                    end
                    // decode short address, then program and/or verify
                    PH_QUERY: begin
                        if (ans == 8'd0) begin
                            st.decoded_short = SHORT_NONE;
                        end else if (ans <= i_short_answer_limit) begin
                            st.decoded_short = ans >> 1;
                        end else begin
                            st.decoded_short = ans;
                        end
                        if (st.assign_mode) begin
                            check_short = {i_state.devices_found, 1'b0};
                            has_verify  = 1'b1;
                            recs[0] = mk_rec(CMD_PROGRAM,
                                             {16'd0, i_state.devices_found, 1'b1},
                                             1'b0, st, ST_OK);
                            k = 3'd1;
                        end else if (st.decoded_short != SHORT_NONE) begin
                            check_short = {st.decoded_short[6:0], 1'b0};
                            has_verify  = 1'b1;
                        end
                        if (has_verify) begin
                            st.phase = PH_VERIFY;
                            recs[k[1:0]] = mk_rec(CMD_VERIFY, {16'd0, check_short[7:1], 1'b1},
                                                  1'b1, st, ST_OK);
                            k = k + 3'd1;
                        end else begin
                            do_close = 1'b1;
                        end
                    end
                    PH_VERIFY: begin
                        if (i_answer_present && i_answer_byte == 8'hFF) begin
                            do_close = 1'b1;
                        end else begin
                            recs[0] = mk_rec(CMD_WAIT, WAIT_MS, 1'b0, st, ST_VERIFY_FAIL);
                            k = 3'd1;
                            do_close     = 1'b1;
                            close_status = ST_VERIFY_FAIL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        // withdraw the handled device and count it
        if (do_close) begin
            recs[k[1:0]] = mk_rec(CMD_WITHDRAW, st.probe_addr, 1'b0, st, close_status);
            k = k + 3'd1;
            st.devices_found = st.devices_found + 7'd1;
            do_begin = 1'b1;
        end

        // start a new search or end the run at the device limit
        if (do_begin) begin
            if (st.devices_found >= i_max_devices) begin
                st.phase = PH_IDLE;
                recs[k[1:0]] = mk_rec(CMD_TERMINATE, 24'd0, 1'b0, st,
                                      (st.devices_found == 7'd0) ? ST_NONE_FOUND
                                                                 : ST_FINISHED);
            end else begin
                st.decoded_short  = SHORT_NONE;
                st.probe_addr     = ADDR_ALL_ONES;
                st.phase          = PH_ALL;
                recs[k[1:0]] = mk_rec(CMD_COMPARE, ADDR_ALL_ONES, 1'b1, st, ST_OK);
            end
            k = k + 3'd1;
        end

        o_state       = st;
        o_bundle.num  = k;
        o_bundle.recs = recs;
    end

endmodule

`default_nettype wire

// ===== verif/dali_address_search_sequencer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dali_address_search_sequencer_unit_test
// Self-checking bench for the commissioning sequencer. Start beats and bus
// answers are driven in random bursts, and the answers come from a small
// simulated bus of devices, with some noise mixed in. A behavioral copy of
// the sequencer predicts every command. Each command beat is checked field by
// field against the oldest prediction while the command side stalls on
// patterns of its own. The run goes through several register settings.
// ----------------------------------------------------------------------------

module dali_address_search_sequencer_unit_test;
    import dass_pkg::*;

    localparam logic [1:0]  OP_IGNORED = 2'd3;
    localparam int          SETTLE     = 8;
    localparam int unsigned TIMEOUT_NS = 2_000_000;

    // expected command beat
    typedef struct packed {
        t_rec rec;
        logic last;
    } t_exp_cmd;

    // one directed stimulus row, with an optional typed-in final command
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] grp;
        logic       pres;
        logic [7:0] ans;
        logic       typed;
        logic [3:0] cmd;
        logic [2:0] st;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [7:0]  i_group_select;
    logic        i_answer_present;
    logic [7:0]  i_answer_byte;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_command;
    logic [23:0] o_command_data;
    logic        o_wants_answer;
    logic        o_last_of_run;
    logic [6:0]  o_device_count;
    logic [23:0] o_found_long_address;
    logic [7:0]  o_dev_short;
    logic [2:0]  o_status;

    // sequencer copy and its registers
    logic [3:0]  pr_phase;
    logic [4:0]  pr_bit;
    logic [23:0] pr_addr;
    logic [6:0]  pr_count;
    logic        pr_assign;
    logic [7:0]  pr_short;
    logic [7:0]  cfg_limit;
    logic [6:0]  cfg_max;

    t_exp_cmd  pending_cmds[$];
    t_exp_cmd  beat_cmds[$];
    t_stim_row stim_rows[$];

    // typed-in final command for the current directed row
    logic       typed_on = 1'b0;
    logic [3:0] typed_cmd;
    logic [2:0] typed_st;

    // simulated bus devices
    logic [23:0] dev_addr [4];
    logic        dev_on [4];
    logic        dev_qpres [4];
    logic [7:0]  dev_qbyte [4];
    logic        dev_vok [4];
    int          n_dev;
    logic        phantom;

    int err_count  = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    int stall_tick = 0;

    dali_address_search_sequencer_unit u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_operation          (i_operation),
        .i_group_select       (i_group_select),
        .i_answer_present     (i_answer_present),
        .i_answer_byte        (i_answer_byte),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_command            (o_command),
        .o_command_data       (o_command_data),
        .o_wants_answer       (o_wants_answer),
        .o_last_of_run        (o_last_of_run),
        .o_device_count       (o_device_count),
        .o_found_long_address (o_found_long_address),
        .o_dev_short          (o_dev_short),
        .o_status             (o_status)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("dali_address_search_sequencer_unit: mismatch");
        $finish;
    end

    task automatic flag_error(input string what, input logic [23:0] got,
                              input logic [23:0] want);
        $display("%0t ns: error on %s: got %0h, want %0h", $time, what, got, want);
        err_count = err_count + 1;
    endtask

    // ------------------------------------------------------------------
    // command prediction
    // ------------------------------------------------------------------

    task automatic add_cmd(input logic [3:0] cmd, input logic [23:0] data,
                           input logic wants, input logic [2:0] st);
        t_exp_cmd e;
        e.rec.command            = cmd;
        e.rec.command_data       = data;
        e.rec.wants_answer       = wants;
        e.rec.device_count       = pr_count;
        e.rec.found_long_address = pr_addr;
        e.rec.dev_short          = pr_short;
        e.rec.status             = st;
        e.last                   = 1'b0;
        beat_cmds.push_back(e);
    endtask

    function automatic logic [2:0] done_status();
        return (pr_count == 7'd0) ? ST_NONE_FOUND : ST_FINISHED;
    endfunction

    task automatic end_run(input logic [2:0] st);
        pr_phase = PH_IDLE;
        add_cmd(CMD_TERMINATE, 24'd0, 1'b0, st);
    endtask

    // look for the next device, or stop at the device limit
    task automatic next_search();
        if (pr_count >= cfg_max) begin
            end_run(done_status());
        end else begin
            pr_short = SHORT_NONE;
            pr_addr  = ADDR_ALL_ONES;
            pr_phase = PH_ALL;
            add_cmd(CMD_COMPARE, pr_addr, 1'b1, ST_OK);
        end
    endtask

    task automatic retire_device(input logic [2:0] st);
        add_cmd(CMD_WITHDRAW, pr_addr, 1'b0, st);
        pr_count = pr_count + 7'd1;
        next_search();
    endtask

    task automatic predict_commands(input logic [1:0] op, input logic [7:0] grp,
                                    input logic pres, input logic [7:0] ans);
        logic [7:0] b;
        logic [7:0] vs;
        t_exp_cmd   tail;
        if (op == OP_START_ASSIGN || op == OP_START_QUERY) begin
            pr_assign = (op == OP_START_ASSIGN);
            pr_count  = 7'd0;
            pr_short  = SHORT_NONE;
            pr_addr   = 24'd0;
            pr_bit    = BIT_TOP;
            add_cmd(CMD_INIT, {16'd0, grp}, 1'b0, ST_OK);
            if (pr_assign) begin
                add_cmd(CMD_RAND, 24'd0, 1'b0, ST_OK);
                add_cmd(CMD_WAIT, WAIT_MS, 1'b0, ST_OK);
            end
            next_search();
        end else if (op == OP_ANSWER) begin
            case (pr_phase)
                PH_ALL: begin
                    if (!pres) begin
                        end_run(done_status());
                    end else begin
                        pr_bit          = BIT_TOP;
                        pr_addr         = 24'd0;
                        pr_addr[pr_bit] = 1'b1;
                        pr_phase        = PH_BITS;
                        add_cmd(CMD_COMPARE, pr_addr, 1'b1, ST_OK);
                    end
                end
                // successive approximation, one address bit per answer
                PH_BITS: begin
                    if (pres)
                        pr_addr[pr_bit] = 1'b0;
                    if (pr_bit == 5'd0) begin
                        if (pr_addr == 24'd0 || pr_addr == ADDR_ALL_ONES) begin
                            end_run(done_status());
                        end else begin
                            pr_phase = PH_FIX;
                            add_cmd(CMD_COMPARE, pr_addr, 1'b1, ST_OK);
                        end
                    end else begin
                        pr_bit          = pr_bit - 5'd1;
                        pr_addr[pr_bit] = 1'b1;
                        add_cmd(CMD_COMPARE, pr_addr, 1'b1, ST_OK);
                    end
                end
                PH_FIX: begin
                    if (!pres)
                        pr_addr = pr_addr + 24'd1;
                    pr_phase = PH_CHECK;
                    add_cmd(CMD_COMPARE, pr_addr, 1'b1, ST_OK);
                end
                PH_CHECK: begin
                    if (!pres) begin
                        end_run(ST_MISMATCH);
                    end else begin
                        pr_phase = PH_QUERY;
                        add_cmd(CMD_QUERY, 24'd0, 1'b1, ST_OK);
                    end
                end
                // decode the short address, then program and/or verify
                PH_QUERY: begin
                    b = pres ? ans : 8'd0;
                    if (b == 8'd0)
                        pr_short = SHORT_NONE;
                    else if (b <= cfg_limit)
                        pr_short = b >> 1;
                    else
                        pr_short = b;
                    if (pr_assign) begin
                        vs = {pr_count, 1'b0};
                        add_cmd(CMD_PROGRAM, {16'd0, vs | 8'd1}, 1'b0, ST_OK);
                    end else if (pr_short != SHORT_NONE) begin
                        vs = {pr_short[6:0], 1'b0};
                    end else begin
                        vs = SHORT_NONE;
                    end
                    if (vs != SHORT_NONE) begin
                        pr_phase = PH_VERIFY;
                        add_cmd(CMD_VERIFY, {16'd0, vs | 8'd1}, 1'b1, ST_OK);
                    end else begin
                        retire_device(ST_OK);
                    end
                end
                PH_VERIFY: begin
                    if (pres && ans == 8'hFF) begin
                        retire_device(ST_OK);
                    end else begin
                        add_cmd(CMD_WAIT, WAIT_MS, 1'b0, ST_VERIFY_FAIL);
                        retire_device(ST_VERIFY_FAIL);
                    end
                end
                default: begin
                end
            endcase
        end
        // flag the final command of the beat and hand the group over
        if (beat_cmds.size() != 0) begin
            tail      = beat_cmds.pop_back();
            tail.last = 1'b1;
            if (typed_on) begin
                tail.rec.command = typed_cmd;
                tail.rec.status  = typed_st;
            end
            beat_cmds.push_back(tail);
            while (beat_cmds.size() != 0)
                pending_cmds.push_back(beat_cmds.pop_front());
        end
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // one input beat, with a random gap ahead of each burst
    task automatic send_beat(input logic [1:0] op, input logic [7:0] grp,
                             input logic pres, input logic [7:0] ans);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_group_select   <= grp;
        i_answer_present <= pres;
        i_answer_byte    <= ans;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_commands(op, grp, pres, ans);
        @(negedge i_clk);
    endtask

    // hold off until every predicted command has come out
    task automatic drain_commands(input int settle);
        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_SHORT_ANSWER_LIMIT)
            cfg_limit = value[7:0];
        else
            cfg_max = value[6:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic [1:0] op, input logic [7:0] grp,
                           input logic pres, input logic [7:0] ans, input logic typed,
                           input logic [3:0] cmd, input logic [2:0] st);
        t_stim_row r;
        r = '{op: op, grp: grp, pres: pres, ans: ans, typed: typed, cmd: cmd, st: st};
        stim_rows.push_back(r);
    endtask

    // one commissioning run against a freshly populated bus, with some noise
    task automatic run_search(input int guard, inout int sent);
        int          d;
        int          r;
        int          steps;
        logic [3:0]  ph_before;
        logic [23:0] addr_before;
        logic [1:0]  op;
        logic        pres;
        logic [7:0]  ans;
        n_dev   = $urandom_range(0, 3);
        phantom = ($urandom_range(0, 9) == 0);
        for (d = 0; d < 4; d++) begin
            case ($urandom_range(0, 7))
                0: dev_addr[d] = 24'h000000;
                1: dev_addr[d] = ADDR_ALL_ONES;
                2: dev_addr[d] = 24'($urandom_range(1, 255));
                default: dev_addr[d] = 24'($urandom);
            endcase
            dev_qpres[d] = 1'b1;
            dev_qbyte[d] = 8'($urandom);
            case ($urandom_range(0, 5))
                0: dev_qpres[d] = 1'b0;
                1: dev_qbyte[d] = 8'h00;
                2: dev_qbyte[d] = 8'($urandom_range(1, 127));
                3: dev_qbyte[d] = 8'($urandom_range(128, 254));
                4: dev_qbyte[d] = 8'hFF;
                default: dev_qbyte[d] = 8'($urandom);
            endcase
            dev_vok[d] = ($urandom_range(0, 4) != 0);
            dev_on[d]  = (d < n_dev);
        end
        op = ($urandom_range(0, 1) == 0) ? OP_START_ASSIGN : OP_START_QUERY;
        send_beat(op, 8'($urandom), 1'($urandom), 8'($urandom));
        sent  = sent + 1;
        steps = 0;
        while (pr_phase != PH_IDLE && steps < guard) begin
            if ($urandom_range(0, 49) == 0)
                drain_commands(0);
            ph_before   = pr_phase;
            addr_before = pr_addr;
            op          = OP_ANSWER;
            pres        = 1'b0;
            ans         = 8'($urandom);
            r           = $urandom_range(0, 99);
            if (r < 2) begin
                op   = OP_IGNORED;
                pres = 1'($urandom);
            end else if (r < 3) begin
                // restart in the middle of a run
                op = ($urandom_range(0, 1) == 0) ? OP_START_ASSIGN : OP_START_QUERY;
                for (d = 0; d < 4; d++)
                    dev_on[d] = (d < n_dev);
            end else if (r < 12) begin
                pres = 1'($urandom);
            end else begin
                case (pr_phase)
                    PH_QUERY: begin
                        for (d = 0; d < 4; d++) begin
                            if (dev_on[d] && dev_addr[d] == pr_addr) begin
                                pres = dev_qpres[d];
                                ans  = dev_qbyte[d];
                            end
                        end
                    end
                    PH_VERIFY: begin
                        pres = 1'($urandom);
                        ans  = 8'($urandom_range(0, 254));
                        for (d = 0; d < 4; d++) begin
                            if (dev_on[d] && dev_addr[d] == pr_addr && dev_vok[d]) begin
                                pres = 1'b1;
                                ans  = 8'hFF;
                            end
                        end
                    end
                    default: begin
                        // a compare is answered by any device at or below the address
                        pres = (pr_phase == PH_ALL) && phantom;
                        for (d = 0; d < 4; d++) begin
                            if (dev_on[d] && dev_addr[d] <= pr_addr)
                                pres = 1'b1;
                        end
                        if (pr_phase == PH_CHECK && $urandom_range(0, 7) == 0)
                            pres = 1'b0;
                    end
                endcase
            end
            send_beat(op, 8'($urandom), pres, ans);
            if (op != OP_IGNORED)
                sent = sent + 1;
            steps = steps + 1;
            // a device leaves the bus once the sequencer withdraws it
            if (op == OP_ANSWER && (ph_before == PH_QUERY || ph_before == PH_VERIFY)
                    && pr_phase != PH_VERIFY) begin
                for (d = 0; d < 4; d++) begin
                    if (dev_addr[d] == addr_before)
                        dev_on[d] = 1'b0;
                end
            end
        end
    endtask

    task automatic run_phase(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            run_search(((budget - sent) < 120) ? (budget - sent) : 120, sent);
            if ($urandom_range(0, 3) == 0)
                send_beat(OP_ANSWER, 8'($urandom), 1'($urandom), 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------

    // receiver stall, on one of four patterns chosen at random
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(20, 120);
            stall_mode = $urandom_range(0, 3);
        end else begin
            stall_left = stall_left - 1;
        end
        stall_tick = (stall_tick + 1) % 5;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_tick < 2);
        endcase
    end

    // compare each command beat with the oldest prediction
    always @(posedge i_clk) begin : check_commands
        t_exp_cmd want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cmds.size() == 0) begin
                flag_error("unexpected command", 24'(o_command), 24'd0);
            end else begin
                want = pending_cmds.pop_front();
                if (o_command !== want.rec.command)
                    flag_error("command", 24'(o_command), 24'(want.rec.command));
                if (o_command_data !== want.rec.command_data)
                    flag_error("command_data", o_command_data, want.rec.command_data);
                if (o_wants_answer !== want.rec.wants_answer)
                    flag_error("wants_answer", 24'(o_wants_answer),
                               24'(want.rec.wants_answer));
                if (o_last_of_run !== want.last)
                    flag_error("last_of_run", 24'(o_last_of_run), 24'(want.last));
                if (o_device_count !== want.rec.device_count)
                    flag_error("device_count", 24'(o_device_count),
                               24'(want.rec.device_count));
                if (o_found_long_address !== want.rec.found_long_address)
                    flag_error("found_long_address", o_found_long_address,
                               want.rec.found_long_address);
                if (o_dev_short !== want.rec.dev_short)
                    flag_error("dev_short", 24'(o_dev_short), 24'(want.rec.dev_short));
                if (o_status !== want.rec.status)
                    flag_error("status", 24'(o_status), 24'(want.rec.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin : main_seq
        int k;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = 3'd0;
        pwdata           = 32'd0;
        i_in_valid       = 1'b0;
        i_operation      = OP_ANSWER;
        i_group_select   = 8'd0;
        i_answer_present = 1'b0;
        i_answer_byte    = 8'd0;

        cfg_limit = 8'd127;
        cfg_max   = 7'd64;
        pr_phase  = PH_IDLE;
        pr_bit    = BIT_TOP;
        pr_addr   = 24'd0;
        pr_count  = 7'd0;
        pr_assign = 1'b0;
        pr_short  = SHORT_NONE;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows: idle and ignored beats, both starts, early endings
        add_row(OP_ANSWER,       8'h00, 1'b1, 8'hFF, 1'b0, CMD_INIT,      ST_OK);
        add_row(OP_IGNORED,      8'hFF, 1'b1, 8'hFF, 1'b0, CMD_INIT,      ST_OK);
        add_row(OP_START_QUERY,  8'hFF, 1'b0, 8'h00, 1'b1, CMD_COMPARE,   ST_OK);
        add_row(OP_ANSWER,       8'h00, 1'b0, 8'h00, 1'b1, CMD_TERMINATE, ST_NONE_FOUND);
        add_row(OP_START_ASSIGN, 8'h00, 1'b1, 8'hFF, 1'b1, CMD_COMPARE,   ST_OK);
        add_row(OP_ANSWER,       8'h00, 1'b1, 8'hFF, 1'b0, CMD_INIT,      ST_OK);
        add_row(OP_ANSWER,       8'hFF, 1'b0, 8'h00, 1'b0, CMD_INIT,      ST_OK);
        add_row(OP_IGNORED,      8'h00, 1'b0, 8'h00, 1'b0, CMD_INIT,      ST_OK);
        add_row(OP_START_QUERY,  8'h5A, 1'b1, 8'hA5, 1'b1, CMD_COMPARE,   ST_OK);
        add_row(OP_ANSWER,       8'h3C, 1'b1, 8'h80, 1'b0, CMD_INIT,      ST_OK);
        add_row(OP_ANSWER,       8'hC3, 1'b1, 8'h7F, 1'b0, CMD_INIT,      ST_OK);
        add_row(OP_START_ASSIGN, 8'h81, 1'b0, 8'h01, 1'b1, CMD_COMPARE,   ST_OK);
        add_row(OP_ANSWER,       8'h7E, 1'b0, 8'hFE, 1'b1, CMD_TERMINATE, ST_NONE_FOUND);
        add_row(OP_ANSWER,       8'h18, 1'b0, 8'h00, 1'b0, CMD_INIT,      ST_OK);
        for (k = 0; k < stim_rows.size(); k++) begin
            typed_on  = stim_rows[k].typed;
            typed_cmd = stim_rows[k].cmd;
            typed_st  = stim_rows[k].st;
            send_beat(stim_rows[k].op, stim_rows[k].grp, stim_rows[k].pres,
                      stim_rows[k].ans);
            typed_on = 1'b0;
        end

        // random runs at the reset settings
        run_phase(55);

        // no shift of query answers, one device per run
        drain_commands(SETTLE);
        write_reg(REG_SHORT_ANSWER_LIMIT, 32'd0);
        write_reg(REG_MAX_DEVICES, 32'd1);
        run_phase(45);

        // every nonzero answer shifted, full device limit
        drain_commands(SETTLE);
        write_reg(REG_SHORT_ANSWER_LIMIT, 32'd255);
        write_reg(REG_MAX_DEVICES, 32'd64);
        run_phase(55);

        // random limit, small device limit
        drain_commands(SETTLE);
        write_reg(REG_SHORT_ANSWER_LIMIT, 32'($urandom_range(1, 254)));
        write_reg(REG_MAX_DEVICES, 32'($urandom_range(2, 5)));
        run_phase(55);

        // device limit already met when a run starts
        drain_commands(SETTLE);
        write_reg(REG_MAX_DEVICES, 32'd0);
        typed_cmd = CMD_TERMINATE;
        typed_st  = ST_NONE_FOUND;
        for (k = 0; k < 4; k++) begin
            typed_on = 1'b1;
            send_beat((k % 2 == 0) ? OP_START_ASSIGN : OP_START_QUERY, 8'($urandom),
                      1'($urandom), 8'($urandom));
            typed_on = 1'b0;
        end

        drain_commands(SETTLE);
        if (err_count == 0 && pending_cmds.size() == 0) begin
            $display("dali_address_search_sequencer_unit: match");
        end else begin
            $display("dali_address_search_sequencer_unit: mismatch");
        end
        $finish;
    end

endmodule
